FILE: hw/rtl/hspr_pkg.sv
// Shared types, codes and constants for the humidity sensor pulse reader.
package hspr_pkg;

    // Parameter defaults
    localparam int FRAME_BITS_DEF  = 40;
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration port geometry
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_ADDR_WIDTH = 3;

    // Register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_START_LOW = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RELEASE   = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_TIMEOUT   = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ZERO_MIN  = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ZERO_MAX  = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ONE_MIN   = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ONE_MAX   = 3'd6;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] RST_START_LOW = 16'd18000;
    localparam logic [CFG_WIDTH-1:0] RST_RELEASE   = 16'd40;
    localparam logic [CFG_WIDTH-1:0] RST_TIMEOUT   = 16'd500;
    localparam logic [CFG_WIDTH-1:0] RST_ZERO_MIN  = 16'd20;
    localparam logic [CFG_WIDTH-1:0] RST_ZERO_MAX  = 16'd30;
    localparam logic [CFG_WIDTH-1:0] RST_ONE_MIN   = 16'd60;
    localparam logic [CFG_WIDTH-1:0] RST_ONE_MAX   = 16'd80;

    // Exclusive window for the sensor response pulses
    localparam logic [CFG_WIDTH-1:0] ACK_MIN = 16'd75;
    localparam logic [CFG_WIDTH-1:0] ACK_MAX = 16'd85;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BAD_ACK = 2'd2;

    // Live register values
    typedef struct packed {
        logic [CFG_WIDTH-1:0] start_low_ticks;
        logic [CFG_WIDTH-1:0] release_ticks;
        logic [CFG_WIDTH-1:0] timeout_ticks;
        logic [CFG_WIDTH-1:0] zero_min;
        logic [CFG_WIDTH-1:0] zero_max;
        logic [CFG_WIDTH-1:0] one_min;
        logic [CFG_WIDTH-1:0] one_max;
    } t_cfg;

    // Control and status part of one result item
    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       busy;
        logic       done;
        logic [1:0] status;
    } t_flags;

endpackage

FILE: hw/rtl/hspr_cfg.sv
// Configuration register file of the pulse reader.
module hspr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hspr_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [hspr_pkg::CFG_WIDTH-1:0]    i_cfg_data,
    output hspr_pkg::t_cfg                    o_cfg
);

    hspr_pkg::t_cfg r_cfg;
    hspr_pkg::t_cfg n_cfg;

    // Decode the write; indexes past the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                hspr_pkg::CFG_START_LOW: n_cfg.start_low_ticks = i_cfg_data;
                hspr_pkg::CFG_RELEASE:   n_cfg.release_ticks   = i_cfg_data;
                hspr_pkg::CFG_TIMEOUT:   n_cfg.timeout_ticks   = i_cfg_data;
                hspr_pkg::CFG_ZERO_MIN:  n_cfg.zero_min        = i_cfg_data;
                hspr_pkg::CFG_ZERO_MAX:  n_cfg.zero_max        = i_cfg_data;
                hspr_pkg::CFG_ONE_MIN:   n_cfg.one_min         = i_cfg_data;
                hspr_pkg::CFG_ONE_MAX:   n_cfg.one_max         = i_cfg_data;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks <= hspr_pkg::RST_START_LOW;
            r_cfg.release_ticks   <= hspr_pkg::RST_RELEASE;
            r_cfg.timeout_ticks   <= hspr_pkg::RST_TIMEOUT;
            r_cfg.zero_min        <= hspr_pkg::RST_ZERO_MIN;
            r_cfg.zero_max        <= hspr_pkg::RST_ZERO_MAX;
            r_cfg.one_min         <= hspr_pkg::RST_ONE_MIN;
            r_cfg.one_max         <= hspr_pkg::RST_ONE_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/hspr_seq.sv
// Read sequencer: line drive, pulse timing and bit assembly, one item per cycle while items are accepted.
module hspr_seq #(
    parameter int FRAME_BITS  = hspr_pkg::FRAME_BITS_DEF,
    parameter int COUNT_WIDTH = hspr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_action,
    input  logic                  i_pin_level,
    input  hspr_pkg::t_cfg        i_cfg,
    output hspr_pkg::t_flags      o_flags,
    output logic [FRAME_BITS-1:0] o_frame
);

    localparam int BC_W  = $clog2(FRAME_BITS + 1);
    localparam int CMP_W = (COUNT_WIDTH > hspr_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                               : hspr_pkg::CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_LOW = 4'd1,
        PH_RELEASE   = 4'd2,
        PH_WAIT_ACK  = 4'd3,
        PH_ACK_LOW   = 4'd4,
        PH_ACK_HIGH  = 4'd5,
        PH_BIT_LOW   = 4'd6,
        PH_BIT_HIGH  = 4'd7
    } t_phase;

    t_phase                 r_phase,    n_phase;
    logic [COUNT_WIDTH-1:0] r_elapsed,  n_elapsed;
    logic [BC_W-1:0]        r_bit_cnt,  n_bit_cnt;
    logic [FRAME_BITS-1:0]  r_frame,    n_frame;
    logic                   r_last_bit, n_last_bit;
    logic [COUNT_WIDTH-1:0] r_ack_low,  n_ack_low;

    logic                   done;
    logic [1:0]             status;
    logic [COUNT_WIDTH-1:0] el_inc;
    logic [CMP_W-1:0]       x_inc, x_el, x_ack;
    logic [CMP_W-1:0]       x_start, x_rel, x_tmo;
    logic [CMP_W-1:0]       x_z_lo, x_z_hi, x_o_lo, x_o_hi, x_a_lo, x_a_hi;
    logic                   tmo_hit, ack_ok, bit_val;
    logic [BC_W-1:0]        bc_inc;

    // Saturating count and widened operands for the compares
    always_comb begin
        el_inc  = (r_elapsed == CNT_MAX) ? r_elapsed : r_elapsed + CNT_ONE;
        x_inc   = CMP_W'(el_inc);
        x_el    = CMP_W'(r_elapsed);
        x_ack   = CMP_W'(r_ack_low);
        x_start = CMP_W'(i_cfg.start_low_ticks);
        x_rel   = CMP_W'(i_cfg.release_ticks);
        x_tmo   = CMP_W'(i_cfg.timeout_ticks);
        x_z_lo  = CMP_W'(i_cfg.zero_min);
        x_z_hi  = CMP_W'(i_cfg.zero_max);
        x_o_lo  = CMP_W'(i_cfg.one_min);
        x_o_hi  = CMP_W'(i_cfg.one_max);
        x_a_lo  = CMP_W'(hspr_pkg::ACK_MIN);
        x_a_hi  = CMP_W'(hspr_pkg::ACK_MAX);
        tmo_hit = x_inc > x_tmo;
        ack_ok  = (x_ack > x_a_lo) && (x_ack < x_a_hi) &&
                  (x_el > x_a_lo) && (x_el < x_a_hi);
        // high time decides the bit; outside both windows the last bit repeats
        if ((x_el > x_z_lo) && (x_el < x_z_hi)) begin
            bit_val = 1'b0;
        end else if ((x_el > x_o_lo) && (x_el < x_o_hi)) begin
            bit_val = 1'b1;
        end else begin
            bit_val = r_last_bit;
        end
        bc_inc = r_bit_cnt + BC_W'(1);
    end

    // Next state for the accepted item
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_bit_cnt  = r_bit_cnt;
        n_frame    = r_frame;
        n_last_bit = r_last_bit;
        n_ack_low  = r_ack_low;
        done       = 1'b0;
        status     = hspr_pkg::ST_OK;
        if (i_accept) begin
            if (i_action) begin
                // start: taken only when idle
                case (r_phase)
                    PH_START_LOW, PH_RELEASE, PH_WAIT_ACK, PH_ACK_LOW,
                    PH_ACK_HIGH, PH_BIT_LOW, PH_BIT_HIGH: n_phase = r_phase;
                    default: begin
                        n_bit_cnt  = '0;
                        n_frame    = '0;
                        n_last_bit = 1'b0;
                        n_ack_low  = '0;
                        n_elapsed  = '0;
                        if (i_cfg.start_low_ticks != '0) begin
                            n_phase = PH_START_LOW;
                        end else if (i_cfg.release_ticks != '0) begin
                            n_phase = PH_RELEASE;
                        end else begin
                            n_phase = PH_WAIT_ACK;
                        end
                    end
                endcase
            end else begin
                case (r_phase)
                    PH_START_LOW: begin
                        n_elapsed = el_inc;
                        if (x_inc >= x_start) begin
                            n_elapsed = '0;
                            n_phase   = (i_cfg.release_ticks != '0) ? PH_RELEASE
                                                                    : PH_WAIT_ACK;
                        end
                    end
                    PH_RELEASE: begin
                        n_elapsed = el_inc;
                        if (x_inc >= x_rel) begin
                            n_elapsed = '0;
                            n_phase   = PH_WAIT_ACK;
                        end
                    end
                    PH_WAIT_ACK: begin
                        if (i_pin_level) begin
                            n_elapsed = el_inc;
                            done      = tmo_hit;
                            status    = tmo_hit ? hspr_pkg::ST_TIMEOUT : hspr_pkg::ST_OK;
                        end else begin
                            n_phase   = PH_ACK_LOW;
                            n_elapsed = CNT_ONE;
                        end
                    end
                    PH_ACK_LOW: begin
                        if (!i_pin_level) begin
                            n_elapsed = el_inc;
                            done      = tmo_hit;
                            status    = tmo_hit ? hspr_pkg::ST_TIMEOUT : hspr_pkg::ST_OK;
                        end else begin
                            n_ack_low = r_elapsed;
                            n_phase   = PH_ACK_HIGH;
                            n_elapsed = CNT_ONE;
                        end
                    end
                    PH_ACK_HIGH: begin
                        if (i_pin_level) begin
                            n_elapsed = el_inc;
                            done      = tmo_hit;
                            status    = tmo_hit ? hspr_pkg::ST_TIMEOUT : hspr_pkg::ST_OK;
                        end else if (!ack_ok) begin
                            done   = 1'b1;
                            status = hspr_pkg::ST_BAD_ACK;
                        end else begin
                            n_phase   = PH_BIT_LOW;
                            n_elapsed = CNT_ONE;
                            n_bit_cnt = '0;
                        end
                    end
                    PH_BIT_LOW: begin
                        if (!i_pin_level) begin
                            n_elapsed = el_inc;
                            done      = tmo_hit;
                            status    = tmo_hit ? hspr_pkg::ST_TIMEOUT : hspr_pkg::ST_OK;
                        end else begin
                            n_phase   = PH_BIT_HIGH;
                            n_elapsed = CNT_ONE;
                        end
                    end
                    PH_BIT_HIGH: begin
                        if (i_pin_level) begin
                            n_elapsed = el_inc;
                            done      = tmo_hit;
                            status    = tmo_hit ? hspr_pkg::ST_TIMEOUT : hspr_pkg::ST_OK;
                        end else begin
                            n_last_bit = bit_val;
                            n_frame    = {r_frame[FRAME_BITS-2:0], bit_val};
                            n_bit_cnt  = bc_inc;
                            if (bc_inc >= BC_W'(FRAME_BITS)) begin
                                done   = 1'b1;
                                status = hspr_pkg::ST_OK;
                            end else begin
                                n_phase   = PH_BIT_LOW;
                                n_elapsed = CNT_ONE;
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            if (done) begin
                n_phase   = PH_IDLE;
                n_elapsed = '0;
            end
        end
    end

    // Result of this item, from the phase it leaves behind
    always_comb begin
        o_flags.drive_enable = (n_phase == PH_START_LOW) || (n_phase == PH_RELEASE);
        o_flags.drive_level  = (n_phase == PH_RELEASE);
        o_flags.busy         = (n_phase != PH_IDLE);
        o_flags.done         = done;
        o_flags.status       = done ? status : hspr_pkg::ST_OK;
        o_frame              = (done && (status == hspr_pkg::ST_OK)) ? n_frame : '0;
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_elapsed  <= '0;
            r_bit_cnt  <= '0;
            r_frame    <= '0;
            r_last_bit <= 1'b0;
            r_ack_low  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_bit_cnt  <= n_bit_cnt;
            r_frame    <= n_frame;
            r_last_bit <= n_last_bit;
            r_ack_low  <= n_ack_low;
        end
    end

endmodule

FILE: hw/rtl/hspr_out.sv
// Result register: holds one item for the receiver and splits out the frame bytes.
module hspr_out #(
    parameter int FRAME_BITS = hspr_pkg::FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_take,
    input  hspr_pkg::t_flags      i_flags,
    input  logic [FRAME_BITS-1:0] i_frame,
    output logic                  o_valid,
    output hspr_pkg::t_flags      o_flags,
    output logic [7:0]            o_humidity,
    output logic [7:0]            o_temperature,
    output logic [FRAME_BITS-1:0] o_frame
);

    logic                  r_valid;
    logic                  n_valid;
    hspr_pkg::t_flags      r_flags;
    logic [FRAME_BITS-1:0] r_frame;

    // Valid stays until the receiver takes the item
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
            r_frame <= i_frame;
        end
    end

    assign o_valid       = r_valid;
    assign o_flags       = r_flags;
    assign o_frame       = r_frame;
    assign o_humidity    = r_frame[FRAME_BITS-1 -: 8];
    assign o_temperature = r_frame[FRAME_BITS-17 -: 8];

endmodule

FILE: hw/rtl/humidity_sensor_pulse_reader.sv
// Top level of the single-wire humidity and temperature sensor reader.
//
// Input channel (i_valid / o_stall): each item is a start command
// (i_action = 1) or a one-microsecond tick (i_action = 0) with the sampled
// line level on i_pin_level. Every item gives exactly one result item on the
// output channel (o_valid / i_stall), in order.
// Result: line drive to apply after the item, busy, done and status, and on a
// good completion the humidity byte, the temperature byte and the raw frame.
// o_valid rises in the cycle after acceptance. Throughput is one item per
// cycle unless the receiver stalls: the sequencer state updates in the accept
// cycle and the result register is reloaded in the same cycle it is taken.
// When the receiver stalls while a result waits, the result register holds
// and o_stall rises, so the next item waits upstream; no item is dropped.
// Reset (synchronous, active low) puts the sequencer idle, clears the
// result valid and loads the default timing registers.
// The user must write registers (i_cfg_we / i_cfg_addr / i_cfg_data) only while
// the block is idle; the block does not enforce it. Unknown indexes are ignored.
module humidity_sensor_pulse_reader #(
    parameter int FRAME_BITS  = hspr_pkg::FRAME_BITS_DEF,
    parameter int COUNT_WIDTH = hspr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hspr_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [hspr_pkg::CFG_WIDTH-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_action,
    input  logic                                i_pin_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_drive_enable,
    output logic                                o_drive_level,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [1:0]                          o_status,
    output logic [7:0]                          o_humidity,
    output logic [7:0]                          o_temperature,
    output logic [FRAME_BITS-1:0]               o_raw_frame
);

    hspr_pkg::t_cfg        cfg;
    hspr_pkg::t_flags      seq_flags;
    hspr_pkg::t_flags      out_flags;
    logic [FRAME_BITS-1:0] seq_frame;
    logic                  in_acc;
    logic                  out_take;

    // Handshake: stall only while a result waits and the receiver stalls
    assign o_stall  = o_valid && i_stall;
    assign in_acc   = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;

    hspr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hspr_seq #(
        .FRAME_BITS  (FRAME_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_action    (i_action),
        .i_pin_level (i_pin_level),
        .i_cfg       (cfg),
        .o_flags     (seq_flags),
        .o_frame     (seq_frame)
    );

    hspr_out #(
        .FRAME_BITS (FRAME_BITS)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_acc),
        .i_take        (out_take),
        .i_flags       (seq_flags),
        .i_frame       (seq_frame),
        .o_valid       (o_valid),
        .o_flags       (out_flags),
        .o_humidity    (o_humidity),
        .o_temperature (o_temperature),
        .o_frame       (o_raw_frame)
    );

    assign o_drive_enable = out_flags.drive_enable;
    assign o_drive_level  = out_flags.drive_level;
    assign o_busy_res     = out_flags.busy;
    assign o_done_res     = out_flags.done;
    assign o_status       = out_flags.status;

    // Every accepted item shows up as a result on the next cycle
    a_acc_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted item did not produce a result");

    // A finished read leaves the block idle and not driving
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (!o_busy_res && !o_drive_enable))
        else $error("read ended while still busy or driving");

    // Frame data only on a good completion
    a_frame_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !(o_done_res && (o_status == hspr_pkg::ST_OK))) |->
        (o_raw_frame == '0))
        else $error("frame shown without a good completion");

    // Driving the line happens only inside a read
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_enable) |-> o_busy_res)
        else $error("line driven while idle");

endmodule
